// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the pacer RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define ASSERT_SYNC(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

// ----- rtl/lrp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and constants of the link rate pacer.
// ----------------------------------------------------------------------------
package lrp_pkg;

    // configuration register widths
    localparam int TICK_W   = 16;
    localparam int LAT_W    = 32;
    localparam int IV_W     = 32;
    localparam int TIME_W   = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // ceiling divider: 32-bit dividend, 16-bit divisor, one bit per cycle
    localparam int DIV_W     = 32;
    localparam int DSR_W     = 16;
    localparam int DIV_CNT_W = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_PERIOD    = 2'd0,
        CFG_ACCESS_LATENCY = 2'd1,
        CFG_ISSUE_INTERVAL = 2'd2
    } cfg_index_t;

    localparam logic [TICK_W-1:0] TICK_RESET = 16'd1000;
    localparam logic [LAT_W-1:0]  LAT_RESET  = 32'd0;
    localparam logic [IV_W-1:0]   IV_RESET   = 32'd1;
    // tick counts derived from the reset values above
    localparam logic [DIV_W-1:0]  SVC_RESET  = 32'd1;
    localparam logic [DIV_W-1:0]  BUSY_RESET = 32'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

// ----- rtl/lrp_ceil_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_ceil_div
// Restoring divider, one quotient bit per cycle, result rounded up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrp_ceil_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [lrp_pkg::DIV_W-1:0]     dividend,
    input  wire logic [lrp_pkg::DSR_W-1:0]     divisor,   // never zero
    output lrp_pkg::div_status_t               status,
    output logic      [lrp_pkg::DIV_W-1:0]     quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [lrp_pkg::DIV_CNT_W-1:0]   count_reg, count_next;
    logic [lrp_pkg::DIV_W-1:0]       quo_reg, quo_next;
    logic [lrp_pkg::DSR_W-1:0]       rem_reg, rem_next;
    logic [lrp_pkg::DSR_W-1:0]       dsr_reg, dsr_next;
    logic [lrp_pkg::DIV_W-1:0]       result_reg, result_next;
    logic [lrp_pkg::DSR_W:0]         shifted;
    logic [lrp_pkg::DSR_W:0]         diff;
    logic                            fits;

    assign shifted = {rem_reg, quo_reg[lrp_pkg::DIV_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        result_next = result_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = lrp_pkg::DIV_CNT_W'(lrp_pkg::DIV_W);
            quo_next   = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end else if (busy_reg) begin
            if (count_reg != '0) begin
                quo_next   = {quo_reg[lrp_pkg::DIV_W-2:0], fits};
                rem_next   = fits ? diff[lrp_pkg::DSR_W-1:0] : shifted[lrp_pkg::DSR_W-1:0];
                count_next = count_reg - 1'b1;
            end else begin
                // round up when anything is left over
                result_next = quo_reg + lrp_pkg::DIV_W'(rem_reg != '0);
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dsr_reg    <= dsr_next;
        result_reg <= result_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = result_reg;

    `ASSERT_SYNC(a_start_busy, aclk, aresetn, start |=> busy_reg, "divider did not start")
    `ASSERT_SYNC(a_done_idle, aclk, aresetn, !(done_reg && busy_reg), "done while still busy")

endmodule
`default_nettype wire

// ----- rtl/lrp_pace_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrp_pace_dp
// Per-tick pacing decision, tick state and running statistics.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrp_pace_dp #(
    parameter int CYCLE_BITS = 48
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          step,
    input  wire logic                          head_valid,
    input  wire logic [CYCLE_BITS-1:0]         head_arrive_cycle,
    input  wire logic [lrp_pkg::TICK_W-1:0]    tick_period,     // zero already mapped to 1
    input  wire logic [lrp_pkg::IV_W-1:0]      issue_interval,  // zero already mapped to 1
    input  wire logic [lrp_pkg::DIV_W-1:0]     svc_ticks,
    input  wire logic [lrp_pkg::DIV_W-1:0]     busy_ticks,
    output logic                               res_issued,
    output logic [9*CYCLE_BITS-1:0]            res_data
);

    localparam int CW    = CYCLE_BITS;
    localparam int EXT_W = ((CW > lrp_pkg::DIV_W) ? CW : lrp_pkg::DIV_W) + 1;
    localparam int TW    = lrp_pkg::TIME_W;
    localparam logic [CW-1:0] CYC_TOP = '1;

    function automatic logic [CW-1:0] sat_cyc(input logic [CW-1:0] a,
                                              input logic [EXT_W-1:0] b);
        logic [EXT_W-1:0] s;
        s = EXT_W'(a) + b;
        return (s[EXT_W-1:CW] != '0) ? CYC_TOP : s[CW-1:0];
    endfunction

    logic [CW-1:0] cycle_reg, cycle_next;
    logic [TW-1:0] time_reg, time_next;
    logic [TW-1:0] next_issue_reg, next_issue_next;
    logic [CW-1:0] served_reg, served_next;
    logic [CW-1:0] wait_sum_reg, wait_sum_next;
    logic [CW-1:0] wait_peak_reg, wait_peak_next;
    logic [CW-1:0] res_sum_reg, res_sum_next;
    logic [CW-1:0] res_peak_reg, res_peak_next;
    logic [CW-1:0] busy_sum_reg, busy_sum_next;
    logic [CW-1:0] completion_reg, completion_next;

    logic [TW:0]   time_sum;
    logic [TW:0]   issue_sum;
    logic          fire;
    logic [CW-1:0] wait_v;
    logic [CW-1:0] depart_v;
    logic [CW-1:0] resid_v;

    always_comb begin
        cycle_next = cycle_reg + CW'(1);
        time_sum   = {1'b0, time_reg} + (TW+1)'(tick_period);
        time_next  = time_sum[TW] ? '1 : time_sum[TW-1:0];

        fire = head_valid && (time_next >= next_issue_reg);

        // on an issue the time has caught up, so the later of the two
        // candidate issue times is always the one based on the time
        issue_sum = {1'b0, time_next} + (TW+1)'(issue_interval);

        wait_v   = (cycle_next >= head_arrive_cycle) ? cycle_next - head_arrive_cycle : '0;
        depart_v = sat_cyc(cycle_next, EXT_W'(svc_ticks));
        resid_v  = (depart_v >= head_arrive_cycle) ? depart_v - head_arrive_cycle : '0;

        next_issue_next = next_issue_reg;
        served_next     = served_reg;
        wait_sum_next   = wait_sum_reg;
        wait_peak_next  = wait_peak_reg;
        res_sum_next    = res_sum_reg;
        res_peak_next   = res_peak_reg;
        busy_sum_next   = busy_sum_reg;
        completion_next = completion_reg;
        if (fire) begin
            next_issue_next = issue_sum[TW] ? '1 : issue_sum[TW-1:0];
            served_next     = sat_cyc(served_reg, EXT_W'(1));
            wait_sum_next   = sat_cyc(wait_sum_reg, EXT_W'(wait_v));
            wait_peak_next  = (wait_v > wait_peak_reg) ? wait_v : wait_peak_reg;
            res_sum_next    = sat_cyc(res_sum_reg, EXT_W'(resid_v));
            res_peak_next   = (resid_v > res_peak_reg) ? resid_v : res_peak_reg;
            busy_sum_next   = sat_cyc(busy_sum_reg, EXT_W'(busy_ticks));
            completion_next = (depart_v > completion_reg) ? depart_v : completion_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_reg      <= '0;
            time_reg       <= '0;
            next_issue_reg <= '0;
            served_reg     <= '0;
            wait_sum_reg   <= '0;
            wait_peak_reg  <= '0;
            res_sum_reg    <= '0;
            res_peak_reg   <= '0;
            busy_sum_reg   <= '0;
            completion_reg <= '0;
        end else if (step) begin
            cycle_reg      <= cycle_next;
            time_reg       <= time_next;
            next_issue_reg <= next_issue_next;
            served_reg     <= served_next;
            wait_sum_reg   <= wait_sum_next;
            wait_peak_reg  <= wait_peak_next;
            res_sum_reg    <= res_sum_next;
            res_peak_reg   <= res_peak_next;
            busy_sum_reg   <= busy_sum_next;
            completion_reg <= completion_next;
        end
    end

    // depart_cycle in the lowest bits, last_completion in the highest
    assign res_issued = fire;
    assign res_data   = {completion_next, busy_sum_next, res_peak_next, res_sum_next,
                         wait_peak_next, wait_sum_next, served_next,
                         fire ? wait_v : CW'(0), fire ? depart_v : CW'(0)};

    `ASSERT_SYNC(a_issue_time_held, aclk, aresetn,
        (step && !fire) |=> $stable(next_issue_reg), "issue time moved without an issue")
    `ASSERT_SYNC(a_served_step, aclk, aresetn,
        1'b1 |=> (served_reg == $past(served_reg)) || (served_reg == $past(served_reg) + 1'b1),
        "served count jumped")

endmodule
`default_nettype wire

// ----- rtl/link_rate_pacer_with_stats_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// link_rate_pacer_with_stats_core
// Fixed-interval link pacer with saturating wait/residence/busy statistics.
// ----------------------------------------------------------------------------
// One input word is one controller tick: it says whether a request waits at
// the head of the external queue and when it arrived. The core advances its
// cycle count and picosecond time, pops the head request once the time has
// reached the next allowed issue time, and returns one result word per input
// word with the departure cycle, the wait and the running statistics. A word
// is accepted every cycle while s_tready is high. Each word passes the input
// register, then the result register, which drives the m_ side. While a
// finished result waits for m_tready the core takes one more word into its
// input register, then holds s_tready low. The service and busy tick counts
// are ceiling divisions by the tick period done by two one-bit-per-cycle
// dividers: after each accepted write to a known register s_tready and
// cfg_ready stay low while they run. No clearing pass is needed after reset.
`include "assert_macros.svh"

module link_rate_pacer_with_stats_core #(
    parameter int CYCLE_BITS = 48
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // tick input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((CYCLE_BITS+7)/8)*8-1:0]   s_tdata,   // head_arrive_cycle
    input  wire logic                              s_tuser,   // head_valid

    // result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // depart_cycle, head wait, served_count, total_wait, max_wait,
    // total_residence, max_residence, link_busy_total, last_completion
    output logic [((9*CYCLE_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                   m_tuser,   // issued

    // register writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lrp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW  = CYCLE_BITS;
    localparam int M_W = ((9*CYCLE_BITS+7)/8)*8;

    // ---- configuration registers ----
    logic [lrp_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [lrp_pkg::LAT_W-1:0]  lat_reg, lat_next;
    logic [lrp_pkg::IV_W-1:0]   iv_reg, iv_next;
    logic                       cfg_hit;
    logic                       div_start_reg;
    logic                       div_busy;

    // derived tick counts
    logic [lrp_pkg::DIV_W-1:0]  svc_reg, busy_ticks_reg;
    logic [lrp_pkg::DIV_W-1:0]  lat_quot, iv_quot;
    lrp_pkg::div_status_t       lat_stat, iv_stat;

    logic [lrp_pkg::TICK_W-1:0] tick_eff;
    logic [lrp_pkg::IV_W-1:0]   iv_eff;

    // ---- pipeline ----
    logic                       in_valid_reg, in_valid_next;
    logic                       in_head_reg;
    logic [CW-1:0]              in_arrive_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_issued_reg;
    logic [9*CW-1:0]            out_data_reg;
    logic                       s_accept;
    logic                       advance;
    logic                       res_issued;
    logic [9*CW-1:0]            res_data;

    // zero period or interval behaves as one
    assign tick_eff = (tick_reg == '0) ? lrp_pkg::TICK_W'(1) : tick_reg;
    assign iv_eff   = (iv_reg == '0)   ? lrp_pkg::IV_W'(1)   : iv_reg;

    assign div_busy  = div_start_reg || lat_stat.busy || iv_stat.busy;
    assign cfg_ready = !div_busy;

    always_comb begin
        tick_next = tick_reg;
        lat_next  = lat_reg;
        iv_next   = iv_reg;
        cfg_hit   = 1'b0;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                lrp_pkg::CFG_TICK_PERIOD: begin
                    tick_next = cfg_data[lrp_pkg::TICK_W-1:0];
                    cfg_hit   = 1'b1;
                end
                lrp_pkg::CFG_ACCESS_LATENCY: begin
                    lat_next = cfg_data[lrp_pkg::LAT_W-1:0];
                    cfg_hit  = 1'b1;
                end
                lrp_pkg::CFG_ISSUE_INTERVAL: begin
                    iv_next = cfg_data[lrp_pkg::IV_W-1:0];
                    cfg_hit = 1'b1;
                end
                default: cfg_hit = 1'b0;   // unknown index, ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= lrp_pkg::TICK_RESET;
            lat_reg        <= lrp_pkg::LAT_RESET;
            iv_reg         <= lrp_pkg::IV_RESET;
            div_start_reg  <= 1'b0;
            svc_reg        <= lrp_pkg::SVC_RESET;
            busy_ticks_reg <= lrp_pkg::BUSY_RESET;
        end else begin
            tick_reg      <= tick_next;
            lat_reg       <= lat_next;
            iv_reg        <= iv_next;
            // dividers start the cycle after the write lands
            div_start_reg <= cfg_hit;
            if (lat_stat.done) begin
                // service takes at least one tick
                svc_reg        <= (lat_quot == '0) ? lrp_pkg::DIV_W'(1) : lat_quot;
                busy_ticks_reg <= iv_quot;
            end
        end
    end

    lrp_ceil_div u_lat_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (lat_reg),
        .divisor  (tick_eff),
        .status   (lat_stat),
        .quotient (lat_quot)
    );

    lrp_ceil_div u_iv_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (iv_eff),
        .divisor  (tick_eff),
        .status   (iv_stat),
        .quotient (iv_quot)
    );

    // ---- handshake: input register -> single pass -> result register ----
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !div_busy && (!in_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_head_reg   <= s_tuser;
            in_arrive_reg <= s_tdata[CW-1:0];
        end
        if (advance) begin
            out_issued_reg <= res_issued;
            out_data_reg   <= res_data;
        end
    end

    lrp_pace_dp #(
        .CYCLE_BITS (CYCLE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (advance),
        .head_valid        (in_head_reg),
        .head_arrive_cycle (in_arrive_reg),
        .tick_period       (tick_eff),
        .issue_interval    (iv_eff),
        .svc_ticks         (svc_reg),
        .busy_ticks        (busy_ticks_reg),
        .res_issued        (res_issued),
        .res_data          (res_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_issued_reg;
    assign m_tdata  = M_W'(out_data_reg);

    `ASSERT_SYNC(a_cfg_holds_input, aclk, aresetn,
        cfg_hit |=> !s_tready, "word accepted while tick counts rebuild")
    `ASSERT_SYNC(a_out_drains, aclk, aresetn,
        (m_tvalid && m_tready && !in_valid_reg) |=> !m_tvalid, "result word repeated")

endmodule
`default_nettype wire

// ----- test/tb_link_rate_pacer_with_stats_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for link_rate_pacer_with_stats_core
// Each tick word sent on the s_ side is run through a cycle-exact pacer
// model in this file. The model produces the expected result word, and every
// m_ word is compared field by field against the oldest queued expectation.
// Both sides idle at random, and once the receiver holds off long enough to
// back the core up. The registers are reloaded between phases while the core
// is idle, extremes included.
// ----------------------------------------------------------------------------
module tb_link_rate_pacer_with_stats_core;

    localparam int CYC_W          = 48;
    localparam int S_DATA_W       = ((CYC_W + 7) / 8) * 8;
    localparam int M_DATA_W       = ((9 * CYC_W + 7) / 8) * 8;
    localparam logic [63:0] CYC_TOP  = (64'd1 << CYC_W) - 64'd1;
    localparam logic [63:0] TIME_TOP = '1;
    localparam logic [lrp_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct packed {
        logic             issued;
        logic [CYC_W-1:0] depart;
        logic [CYC_W-1:0] qwait;
        logic [CYC_W-1:0] served;
        logic [CYC_W-1:0] wsum;
        logic [CYC_W-1:0] wmax;
        logic [CYC_W-1:0] rsum;
        logic [CYC_W-1:0] rmax;
        logic [CYC_W-1:0] busy;
        logic [CYC_W-1:0] lastc;
    } pacer_result_t;

    // clock, reset and DUT inputs, all known from time zero
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0]            s_tdata   = '0;    // head_arrive_cycle
    logic                           s_tuser   = 1'b0;  // head_valid
    logic                           m_tready  = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic [lrp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lrp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  s_tready;
    logic                  m_tvalid;
    // depart_cycle, head wait, served_count, total_wait, max_wait,
    // total_residence, max_residence, link_busy_total, last_completion
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;               // issued
    logic                  cfg_ready;

    // pacer model: register copies and derived tick counts
    logic [lrp_pkg::TICK_W-1:0] tick_cfg = lrp_pkg::TICK_RESET;
    logic [lrp_pkg::LAT_W-1:0]  lat_cfg  = lrp_pkg::LAT_RESET;
    logic [lrp_pkg::IV_W-1:0]   iv_cfg   = lrp_pkg::IV_RESET;
    logic [63:0]           svc_ticks_cur;
    logic [63:0]           busy_ticks_cur;

    // pacer model: running state
    logic [CYC_W-1:0]      cyc_now    = '0;
    logic [63:0]           ps_now     = '0;
    logic [63:0]           ps_next_issue = '0;
    logic [CYC_W-1:0]      served     = '0;
    logic [CYC_W-1:0]      wait_total = '0;
    logic [CYC_W-1:0]      wait_max   = '0;
    logic [CYC_W-1:0]      res_total  = '0;
    logic [CYC_W-1:0]      res_max    = '0;
    logic [CYC_W-1:0]      busy_total = '0;
    logic [CYC_W-1:0]      done_max   = '0;

    pacer_result_t         pending_results[$];
    int                    mismatches = 0;
    int                    ticks_sent = 0;
    int                    stalled_cycles = 0;
    bit                    no_idle  = 1'b0;
    bit                    hold_req = 1'b0;

    always #5 aclk = ~aclk;

    link_rate_pacer_with_stats_core #(
        .CYCLE_BITS (CYC_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Pacer model
    // ------------------------------------------------------------------
    function automatic logic [63:0] sat_sum(input logic [63:0] a, b, top);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, top}) ? top : s[63:0];
    endfunction

    // a zero period or interval counts as one
    function automatic logic [63:0] period_ps();
        return (tick_cfg == '0) ? 64'd1 : 64'(tick_cfg);
    endfunction

    function automatic logic [63:0] interval_ps();
        return (iv_cfg == '0) ? 64'd1 : 64'(iv_cfg);
    endfunction

    // ceiling divisions, redone on every register write
    function automatic void rederive();
        logic [63:0] t;
        t = period_ps();
        svc_ticks_cur = (64'(lat_cfg) + t - 64'd1) / t;
        if (svc_ticks_cur == 64'd0)
            svc_ticks_cur = 64'd1;
        busy_ticks_cur = (interval_ps() + t - 64'd1) / t;
    endfunction

    function automatic void apply_reg(input logic [lrp_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [lrp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            lrp_pkg::CFG_TICK_PERIOD:    tick_cfg = data[lrp_pkg::TICK_W-1:0];
            lrp_pkg::CFG_ACCESS_LATENCY: lat_cfg  = data[lrp_pkg::LAT_W-1:0];
            lrp_pkg::CFG_ISSUE_INTERVAL: iv_cfg   = data[lrp_pkg::IV_W-1:0];
            default: ;  // unmapped index: nothing changes
        endcase
        rederive();
    endfunction

    // one tick: advance time, pop the head if the pacing window is open
    function automatic void pace_tick(input logic hv, input logic [CYC_W-1:0] arr);
        pacer_result_t r;
        logic [63:0]   dep;
        logic [63:0]   stay;
        logic [CYC_W-1:0] qw;
        r = '0;
        cyc_now = cyc_now + 1'b1;
        ps_now  = sat_sum(ps_now, period_ps(), TIME_TOP);
        if (hv && ps_now >= ps_next_issue) begin
            qw   = (cyc_now >= arr) ? cyc_now - arr : '0;
            dep  = sat_sum(64'(cyc_now), svc_ticks_cur, CYC_TOP);
            stay = (dep >= 64'(arr)) ? dep - 64'(arr) : 64'd0;
            served     = CYC_W'(sat_sum(64'(served), 64'd1, CYC_TOP));
            wait_total = CYC_W'(sat_sum(64'(wait_total), 64'(qw), CYC_TOP));
            res_total  = CYC_W'(sat_sum(64'(res_total), stay, CYC_TOP));
            busy_total = CYC_W'(sat_sum(64'(busy_total), busy_ticks_cur, CYC_TOP));
            if (qw > wait_max)
                wait_max = qw;
            if (stay > 64'(res_max))
                res_max = CYC_W'(stay);
            if (dep > 64'(done_max))
                done_max = CYC_W'(dep);
            if (sat_sum(ps_next_issue, interval_ps(), TIME_TOP) >
                sat_sum(ps_now, interval_ps(), TIME_TOP))
                ps_next_issue = sat_sum(ps_next_issue, interval_ps(), TIME_TOP);
            else
                ps_next_issue = sat_sum(ps_now, interval_ps(), TIME_TOP);
            r.issued = 1'b1;
            r.depart = CYC_W'(dep);
            r.qwait  = qw;
        end
        r.served = served;
        r.wsum   = wait_total;
        r.wmax   = wait_max;
        r.rsum   = res_total;
        r.rmax   = res_max;
        r.busy   = busy_total;
        r.lastc  = done_max;
        pending_results = {pending_results, r};
    endfunction

    // ------------------------------------------------------------------
    // Monitor: model update on accepted words, result check, watchdog
    // ------------------------------------------------------------------
    function automatic void check_field(input string name,
                                        input logic [CYC_W-1:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : monitor
        pacer_result_t want;
        bit moved;
        if (aresetn) begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready) begin
                apply_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                pace_tick(s_tuser, s_tdata[CYC_W-1:0]);
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result word with no expectation pending");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("issued", CYC_W'(want.issued), CYC_W'(m_tuser));
                    check_field("depart_cycle",    want.depart, m_tdata[0*CYC_W +: CYC_W]);
                    check_field("head_wait",       want.qwait,  m_tdata[1*CYC_W +: CYC_W]);
                    check_field("served_count",    want.served, m_tdata[2*CYC_W +: CYC_W]);
                    check_field("total_wait",      want.wsum,   m_tdata[3*CYC_W +: CYC_W]);
                    check_field("max_wait",        want.wmax,   m_tdata[4*CYC_W +: CYC_W]);
                    check_field("total_residence", want.rsum,   m_tdata[5*CYC_W +: CYC_W]);
                    check_field("max_residence",   want.rmax,   m_tdata[6*CYC_W +: CYC_W]);
                    check_field("link_busy_total", want.busy,   m_tdata[7*CYC_W +: CYC_W]);
                    check_field("last_completion", want.lastc,  m_tdata[8*CYC_W +: CYC_W]);
                end
            end
            stalled_cycles = moved ? 0 : stalled_cycles + 1;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_link_rate_pacer_with_stats_core: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, plus one long hold-off when asked
    initial begin : result_sink
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // valid stays up from one word to the next unless a gap is drawn
    task automatic send_tick(input logic hv, input logic [CYC_W-1:0] arr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= hv;
        s_tdata  <= S_DATA_W'(arr);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    // arrival cycles mostly trail the coming cycle by a little; some lie
    // ahead of it and some are anywhere in the 48-bit range
    function automatic logic [CYC_W-1:0] pick_arrival();
        logic [CYC_W-1:0] upcoming;
        int r;
        int k;
        upcoming = CYC_W'(ticks_sent + 1);
        r = $urandom_range(0, 99);
        if (r < 20)
            return CYC_W'({$urandom, $urandom});
        if (r < 30)
            return upcoming + CYC_W'($urandom_range(0, 20));
        k = $urandom_range(0, 80);
        if (k > ticks_sent + 1)
            k = ticks_sent + 1;
        return upcoming - CYC_W'(k);
    endfunction

    task automatic send_random_ticks(input int count);
        repeat (count)
            send_tick($urandom_range(0, 99) < 85, pick_arrival());
    endtask

    // park the sender and wait until every expected word is out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // valid drops for one cycle after each write
    task automatic write_reg(input logic [lrp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lrp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // reset settings: 1 ps interval, so every waiting head is popped
    task automatic test_reset_defaults();
        logic [CYC_W-1:0] nxt;
        send_tick(1'b0, '0);
        send_tick(1'b0, '1);
        send_tick(1'b1, '0);
        nxt = CYC_W'(ticks_sent + 1);
        send_tick(1'b1, nxt);                       // no wait
        nxt = CYC_W'(ticks_sent + 1);
        send_tick(1'b1, nxt + 1'b1);                // arrives at its departure
        send_tick(1'b1, '1);                        // arrives after departure
        send_tick(1'b1, 48'hAAAA_AAAA_AAAA);
        send_tick(1'b1, 48'h5555_5555_5555);
        send_tick(1'b1, 48'h8000_0000_0000);
        repeat (6) begin
            nxt = CYC_W'(ticks_sent + 1);
            send_tick(1'b1, nxt - CYC_W'($urandom_range(0, 5)));
        end
    endtask

    // zero period and zero interval fall back to one; upper data bits of
    // the period write are junk and must be dropped
    task automatic test_zero_period_interval();
        drain();
        write_reg(lrp_pkg::CFG_TICK_PERIOD, {16'hFFFF, 16'h0000});
        write_reg(lrp_pkg::CFG_ISSUE_INTERVAL, '0);
        send_random_ticks(40);
    endtask

    // random settings; intervals stay within a few ticks so the pacing
    // window never drifts far ahead of the next phase
    task automatic test_random_settings();
        logic [lrp_pkg::TICK_W-1:0] tick;
        logic [lrp_pkg::LAT_W-1:0]  lat;
        logic [lrp_pkg::IV_W-1:0]   iv;
        int sel;
        for (int p = 0; p < 8; p++) begin
            drain();
            no_idle = ($urandom_range(0, 3) == 0);
            tick = lrp_pkg::TICK_W'($urandom_range(1, 64));
            sel  = $urandom_range(0, 2);
            lat  = (sel == 0) ? lrp_pkg::LAT_W'($urandom_range(0, 500)) :
                   (sel == 1) ? lrp_pkg::LAT_W'($urandom) : '0;
            iv   = lrp_pkg::IV_W'($urandom_range(1, 4 * tick));
            if (p == 3) begin
                // all-ones latency: the remainder forces a round up
                tick = 16'd2;
                lat  = '1;
                iv   = 32'd8;
            end
            if (p == 5) begin
                tick = 16'd1;
                iv   = 32'd1;
            end
            write_reg(lrp_pkg::CFG_TICK_PERIOD, {16'($urandom), tick});
            write_reg(lrp_pkg::CFG_ACCESS_LATENCY, lat);
            write_reg(lrp_pkg::CFG_ISSUE_INTERVAL, iv);
            if (p == 6)
                write_reg(CFG_UNMAPPED, $urandom);
            send_random_ticks(125);
        end
        no_idle = 1'b0;
    endtask

    // receiver stops for a long stretch while words keep coming
    task automatic test_output_backpressure();
        drain();
        no_idle  = 1'b1;
        hold_req = 1'b1;
        send_random_ticks(300);
        no_idle  = 1'b0;
    endtask

    task automatic test_slowest_tick();
        drain();
        write_reg(lrp_pkg::CFG_TICK_PERIOD, 32'h0000_FFFF);
        write_reg(lrp_pkg::CFG_ACCESS_LATENCY, '1);
        write_reg(lrp_pkg::CFG_ISSUE_INTERVAL, 32'd196605);
        send_random_ticks(100);
    endtask

    // one issue, then the window lies beyond the rest of the run
    task automatic test_widest_interval();
        drain();
        write_reg(lrp_pkg::CFG_ACCESS_LATENCY, '0);
        write_reg(lrp_pkg::CFG_ISSUE_INTERVAL, '1);
        send_random_ticks(40);
    endtask

    initial begin
        rederive();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_zero_period_interval();
        test_random_settings();
        test_output_backpressure();
        test_slowest_tick();
        test_widest_interval();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_link_rate_pacer_with_stats_core: clean");
        else
            $display("tb_link_rate_pacer_with_stats_core: errors");
        $finish;
    end

endmodule
